// ===== src/fssce_pkg.sv =====
// Shared constants, codes and helpers of the serial frame-store command engine.
`default_nettype none

package fssce_pkg;

  // Frame geometry: frames are stored as 64-bit words of eight bytes
  localparam int DEF_FRAMES  = 1024;
  localparam int FRAME_BYTES = 128;
  localparam int WORD_BYTES  = 8;
  localparam int WORDS       = FRAME_BYTES / WORD_BYTES;
  localparam int WORD_AW     = $clog2(WORDS);

  // Reply status bytes and sector limit for writes
  localparam logic [7:0]  STATUS_GOOD       = 8'h47;
  localparam logic [7:0]  STATUS_BAD_CSUM   = 8'h4E;
  localparam logic [7:0]  STATUS_BAD_SECTOR = 8'hFF;
  localparam logic [15:0] SECTOR_LIMIT      = 16'd1024;
  localparam logic [15:0] IDLE_MAX          = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] CFG_CMD_GET_ID      = 3'd0;
  localparam logic [2:0] CFG_CMD_GET_VERSION = 3'd1;
  localparam logic [2:0] CFG_CMD_READ_FRAME  = 3'd2;
  localparam logic [2:0] CFG_CMD_WRITE_FRAME = 3'd3;
  localparam logic [2:0] CFG_REPLY_ERROR     = 3'd4;
  localparam logic [2:0] CFG_REPLY_IDENT     = 3'd5;
  localparam logic [2:0] CFG_REPLY_VERSION   = 3'd6;

  // Parser phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RD_MSB  = 3'd1;
  localparam logic [2:0] PH_RD_LSB  = 3'd2;
  localparam logic [2:0] PH_WR_MSB  = 3'd3;
  localparam logic [2:0] PH_WR_LSB  = 3'd4;
  localparam logic [2:0] PH_WR_DATA = 3'd5;
  localparam logic [2:0] PH_WR_CSUM = 3'd6;

  typedef logic [8*WORD_BYTES-1:0] word_t;

  // XOR of the eight bytes of a word
  function automatic logic [7:0] xor_fold(input word_t w);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < WORD_BYTES; i++) begin
      acc = acc ^ w[8*i +: 8];
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== src/frame_store_serial_command_engine.sv =====
// Top level: command parser, staging buffer and frame store of the serial engine.
`default_nettype none

// Serial frame-store command engine. Each item is a received byte or an idle
// tick; it is accepted when start is high and busy is low, and yields one or
// more results on out_valid, each valid for exactly one cycle (the receiver
// cannot stall). A tick or a byte that only feeds the parser gives one result,
// registered from the execute state; busy is high there, so the next item
// waits until the parser is through. The LSB of a read gives 17 results on
// consecutive cycles, 16 data words and one word with checksum and status:
// the frame store has one read port that delivers one 64-bit word per cycle.
// A good write checksum for a sector inside the store copies the staged frame
// in 16 words through the single staging read port, keeping busy high while
// it runs. After reset the frame store is erased to 0xFF by a clearing pass
// over all FRAMES*16 words (16384 at the default size) during which busy is
// high; configuration writes are taken at all times.
module frame_store_serial_command_engine #(
  parameter int FRAMES = fssce_pkg::DEF_FRAMES
) (
  input  wire         clk,
  input  wire         rst_n,
  // Item channel
  input  wire         start,
  output logic        busy,
  input  wire         in_opcode,
  input  wire  [7:0]  in_rx_byte,
  // Result channel
  output logic        out_valid,
  output logic [63:0] out_tx_bytes,
  output logic [3:0]  out_tx_count,
  output logic [15:0] out_idle_count,
  output logic        out_last,
  // Configuration channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  import fssce_pkg::*;

  localparam int FAW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AW    = FAW + WORD_AW;
  localparam int DEPTH = FRAMES * WORDS;

  localparam logic [4:0] CNT_LAST_WORD = 5'(WORDS);
  localparam logic [4:0] CNT_STATUS    = 5'(WORDS + 1);

  // Engine states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [15:0]   sector_r, sector_nxt;
  logic [7:0]    bidx_r, bidx_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [15:0]   idle_r, idle_nxt;
  logic          op_r, op_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  word_t         pack_r, pack_nxt;

  logic          out_valid_r, out_valid_nxt;
  word_t         out_bytes_r, out_bytes_nxt;
  logic [3:0]    out_count_r, out_count_nxt;
  logic          out_last_r, out_last_nxt;

  logic [7:0] cmd_id_r, cmd_ver_r, cmd_rd_r, cmd_wr_r;
  logic [7:0] rep_err_r, rep_id_r, rep_ver_r;

  // Memories
  word_t frame_mem [DEPTH];
  word_t stage_mem [WORDS];

  logic                fr_we;
  logic [AW-1:0]       fr_waddr;
  word_t               fr_wdata;
  logic [AW-1:0]       fr_raddr;
  word_t               fr_q;
  logic                st_we;
  logic [WORD_AW-1:0]  st_waddr;
  word_t               st_wdata;
  logic [WORD_AW-1:0]  st_raddr;
  word_t               st_q;

  logic                sector_in_range;
  word_t               rd_word;

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_tx_bytes    = out_bytes_r;
  assign out_tx_count    = out_count_r;
  assign out_last        = out_last_r;
  assign out_idle_count  = idle_r;

  assign sector_in_range = (sector_r < 16'(FRAMES));
  assign rd_word         = sector_in_range ? fr_q : '1;
  assign fr_raddr        = {sector_r[FAW-1:0], cnt_r[WORD_AW-1:0]};
  assign st_raddr        = cnt_r[WORD_AW-1:0];
  assign st_waddr        = bidx_r[6:3];
  assign st_wdata        = {byte_r, pack_r[8*WORD_BYTES-9:0]};

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= fr_wdata;
    end
    fr_q <= frame_mem[fr_raddr];
  end

  // Staging buffer for an incoming frame
  always_ff @(posedge clk) begin
    if (st_we) begin
      stage_mem[st_waddr] <= st_wdata;
    end
    st_q <= stage_mem[st_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_id_r  <= 8'hA0;
      cmd_ver_r <= 8'hA1;
      cmd_rd_r  <= 8'hA2;
      cmd_wr_r  <= 8'hA3;
      rep_err_r <= 8'hE0;
      rep_id_r  <= 8'hAA;
      rep_ver_r <= 8'h04;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CMD_GET_ID:      cmd_id_r  <= cfg_data;
        CFG_CMD_GET_VERSION: cmd_ver_r <= cfg_data;
        CFG_CMD_READ_FRAME:  cmd_rd_r  <= cfg_data;
        CFG_CMD_WRITE_FRAME: cmd_wr_r  <= cfg_data;
        CFG_REPLY_ERROR:     rep_err_r <= cfg_data;
        CFG_REPLY_IDENT:     rep_id_r  <= cfg_data;
        CFG_REPLY_VERSION:   rep_ver_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser, burst sequencing and memory control
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    sector_nxt    = sector_r;
    bidx_nxt      = bidx_r;
    xor_nxt       = xor_r;
    idle_nxt      = idle_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    cnt_nxt       = cnt_r;
    clr_addr_nxt  = clr_addr_r;
    pack_nxt      = pack_r;
    out_valid_nxt = 1'b0;
    out_bytes_nxt = '0;
    out_count_nxt = 4'd0;
    out_last_nxt  = 1'b0;
    fr_we         = 1'b0;
    fr_waddr      = clr_addr_r;
    fr_wdata      = '1;
    st_we         = 1'b0;

    unique case (state_r)
      // Erase the frame store one word a cycle
      S_CLEAR: begin
        fr_we        = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take an item
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          byte_nxt  = in_rx_byte;
          state_nxt = S_EXEC;
        end
      end

      // Advance the parser by one item
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (op_r) begin
          if (idle_r != IDLE_MAX) begin
            idle_nxt = idle_r + 16'd1;
          end
        end else begin
          idle_nxt = 16'd0;
          unique case (phase_r)
            PH_RD_MSB, PH_WR_MSB: begin
              sector_nxt = {byte_r, 8'h00};
              xor_nxt    = byte_r;
              phase_nxt  = (phase_r == PH_RD_MSB) ? PH_RD_LSB : PH_WR_LSB;
            end
            PH_RD_LSB: begin
              sector_nxt    = sector_r | {8'h00, byte_r};
              xor_nxt       = xor_r ^ byte_r;
              phase_nxt     = PH_IDLE;
              out_valid_nxt = 1'b0;
              out_last_nxt  = 1'b0;
              cnt_nxt       = 5'd0;
              state_nxt     = S_READ;
            end
            PH_WR_LSB: begin
              sector_nxt = sector_r | {8'h00, byte_r};
              xor_nxt    = xor_r ^ byte_r;
              bidx_nxt   = 8'd0;
              phase_nxt  = PH_WR_DATA;
            end
            PH_WR_DATA: begin
              pack_nxt[8*bidx_r[2:0] +: 8] = byte_r;
              st_we    = (bidx_r[2:0] == 3'd7);
              xor_nxt  = xor_r ^ byte_r;
              bidx_nxt = bidx_r + 8'd1;
              if (bidx_nxt[7]) begin
                phase_nxt = PH_WR_CSUM;
              end
            end
            PH_WR_CSUM: begin
              phase_nxt     = PH_IDLE;
              out_count_nxt = 4'd1;
              if (sector_r > SECTOR_LIMIT) begin
                out_bytes_nxt = word_t'(STATUS_BAD_SECTOR);
              end else if (xor_r == byte_r) begin
                out_bytes_nxt = word_t'(STATUS_GOOD);
                if (sector_in_range) begin
                  cnt_nxt   = 5'd0;
                  state_nxt = S_COPY;
                end
              end else begin
                out_bytes_nxt = word_t'(STATUS_BAD_CSUM);
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              priority if (byte_r == cmd_id_r) begin
                out_bytes_nxt = word_t'(rep_id_r);
                out_count_nxt = 4'd1;
              end else if (byte_r == cmd_ver_r) begin
                out_bytes_nxt = word_t'(rep_ver_r);
                out_count_nxt = 4'd1;
              end else if (byte_r == cmd_rd_r) begin
                phase_nxt = PH_RD_MSB;
              end else if (byte_r == cmd_wr_r) begin
                phase_nxt = PH_WR_MSB;
              end else begin
                out_bytes_nxt = word_t'(rep_err_r);
                out_count_nxt = 4'd1;
              end
            end
          endcase
        end
      end

      // Stream the frame out one word a cycle, then checksum and status
      S_READ: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CNT_STATUS) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = word_t'({STATUS_GOOD, xor_r});
          out_count_nxt = 4'd2;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else if (cnt_r != 5'd0) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = rd_word;
          out_count_nxt = 4'(WORD_BYTES);
          xor_nxt       = xor_r ^ xor_fold(rd_word);
        end
      end

      // Copy the staged frame into the store
      S_COPY: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r != 5'd0) begin
          fr_we    = 1'b1;
          fr_waddr = {sector_r[FAW-1:0], WORD_AW'(cnt_r - 5'd1)};
          fr_wdata = st_q;
        end
        if (cnt_r == CNT_LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_IDLE;
      sector_r    <= 16'd0;
      bidx_r      <= 8'd0;
      xor_r       <= 8'd0;
      idle_r      <= 16'd0;
      cnt_r       <= 5'd0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      sector_r    <= sector_nxt;
      bidx_r      <= bidx_nxt;
      xor_r       <= xor_nxt;
      idle_r      <= idle_nxt;
      cnt_r       <= cnt_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    pack_r      <= pack_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_count_r <= out_count_nxt;
  end

`ifndef SYNTHESIS
  // No result while the store is being erased
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result strobed during clearing pass");

  // An accepted item is worked on in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

  // The last result of an item is never directly followed by another
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result directly after last");

  // A result never claims more than eight bytes
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= 4'd8))
    else $error("byte count out of range");

  // The frame store is only written by the erase and copy sequences
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    fr_we |-> (state_r == S_CLEAR || state_r == S_COPY))
    else $error("frame store written outside erase or copy");
`endif

endmodule

`default_nettype wire

// ===== dv/frame_store_serial_command_engine_tb.sv =====
// Self-checking testbench: directed and random link traffic against a built-in engine predictor.
module frame_store_serial_command_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fssce_pkg::*;

  localparam int N_FRAMES     = DEF_FRAMES;
  localparam int ITEMS_TARGET = 230;
  localparam int SETTLE       = 40;
  localparam int MAX_SHOWN    = 20;

  typedef struct packed {
    logic [63:0] tx_bytes;
    logic [3:0]  tx_count;
    logic [15:0] idle_count;
    logic        last;
  } reply_t;

  typedef struct packed {
    logic        is_tick;
    logic [7:0]  rx;
    logic        typed;
    logic [63:0] tx;
    logic [3:0]  cnt;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic [63:0] out_tx_bytes;
  logic [3:0]  out_tx_count;
  logic [15:0] out_idle_count;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Engine predictor state
  logic [7:0]  cfg_shadow [7];
  logic [2:0]  parse_phase;
  logic [15:0] sector;
  logic [7:0]  wr_index;
  logic [7:0]  csum;
  logic [15:0] ticks;
  logic [7:0]  staged [FRAME_BYTES];
  logic [7:0]  store_img [N_FRAMES*FRAME_BYTES];

  reply_t      pending_replies[$];
  logic [7:0]  reply_bytes[$];
  int          last_pushed;

  int          error_count;
  int          results_checked;
  int          items_sent;
  int          frames_committed;
  logic        burst_mode;
  logic [15:0] recent_sector;

  // Directed stimulus; typed rows carry their expected single reply
  step_row_t directed_rows [21] = '{
    '{1'b0, 8'hA0, 1'b1, 64'hAA, 4'd1},  // get-id
    '{1'b0, 8'hA1, 1'b1, 64'h04, 4'd1},  // get-version
    '{1'b0, 8'h00, 1'b1, 64'hE0, 4'd1},  // unknown, low extreme
    '{1'b0, 8'hFF, 1'b1, 64'hE0, 4'd1},  // unknown, high extreme
    '{1'b0, 8'hA4, 1'b1, 64'hE0, 4'd1},  // just past the write command
    '{1'b1, 8'h00, 1'b0, 64'h00, 4'd0},
    '{1'b1, 8'hFF, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'h5A, 1'b1, 64'hE0, 4'd1},  // byte clears the idle count
    '{1'b0, 8'hA2, 1'b1, 64'h00, 4'd0},  // read of erased sector 0
    '{1'b1, 8'h00, 1'b0, 64'h00, 4'd0},  // tick mid-command keeps the phase
    '{1'b0, 8'h00, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'h00, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'hA2, 1'b1, 64'h00, 4'd0},  // read of the last frame
    '{1'b0, 8'h03, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'hFF, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'hA2, 1'b1, 64'h00, 4'd0},  // read just past the store
    '{1'b0, 8'h04, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'h00, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'hA2, 1'b1, 64'h00, 4'd0},  // read of the highest sector
    '{1'b0, 8'hFF, 1'b0, 64'h00, 4'd0},
    '{1'b0, 8'hFF, 1'b0, 64'h00, 4'd0}
  };

  frame_store_serial_command_engine #(
    .FRAMES(N_FRAMES)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_tx_bytes  (out_tx_bytes),
    .out_tx_count  (out_tx_count),
    .out_idle_count(out_idle_count),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Pack the reply bytes eight per result, stamped with the idle count
  task automatic emit_replies();
    reply_t r;
    int     pos;
    int     k;
    pos = 0;
    last_pushed = 0;
    do begin
      r = '0;
      for (k = 0; k < 8 && pos < reply_bytes.size(); k++) begin
        r.tx_bytes[8*k +: 8] = reply_bytes[pos];
        pos++;
      end
      r.tx_count   = 4'(k);
      r.idle_count = ticks;
      r.last       = (pos >= reply_bytes.size());
      pending_replies.push_back(r);
      last_pushed++;
    end while (pos < reply_bytes.size());
  endtask

  // Advance the predictor by one accepted transaction
  task automatic predict_item(input logic tick, input logic [7:0] rx);
    logic [7:0] d;
    int         i;
    reply_bytes.delete();
    if (tick) begin
      if (ticks != IDLE_MAX) ticks++;
    end else begin
      ticks = '0;
      case (parse_phase)
        PH_RD_MSB, PH_WR_MSB: begin
          sector      = {rx, 8'h00};
          csum        = rx;
          parse_phase = (parse_phase == PH_RD_MSB) ? PH_RD_LSB : PH_WR_LSB;
        end
        PH_RD_LSB: begin
          sector[7:0] = rx;
          csum        = csum ^ rx;
          for (i = 0; i < FRAME_BYTES; i++) begin
            d = (sector < N_FRAMES) ? store_img[int'(sector)*FRAME_BYTES + i] : 8'hFF;
            csum = csum ^ d;
            reply_bytes.push_back(d);
          end
          reply_bytes.push_back(csum);
          reply_bytes.push_back(STATUS_GOOD);
          parse_phase = PH_IDLE;
        end
        PH_WR_LSB: begin
          sector[7:0] = rx;
          csum        = csum ^ rx;
          wr_index    = '0;
          parse_phase = PH_WR_DATA;
        end
        PH_WR_DATA: begin
          staged[wr_index[6:0]] = rx;
          csum     = csum ^ rx;
          wr_index = wr_index + 8'd1;
          if (wr_index >= FRAME_BYTES) parse_phase = PH_WR_CSUM;
        end
        PH_WR_CSUM: begin
          if (sector > SECTOR_LIMIT) begin
            reply_bytes.push_back(STATUS_BAD_SECTOR);
          end else if (csum == rx) begin
            if (sector < N_FRAMES) begin
              for (i = 0; i < FRAME_BYTES; i++)
                store_img[int'(sector)*FRAME_BYTES + i] = staged[i];
              frames_committed++;
            end
            reply_bytes.push_back(STATUS_GOOD);
          end else begin
            reply_bytes.push_back(STATUS_BAD_CSUM);
          end
          parse_phase = PH_IDLE;
        end
        default: begin
          parse_phase = PH_IDLE;
          if (rx == cfg_shadow[CFG_CMD_GET_ID])
            reply_bytes.push_back(cfg_shadow[CFG_REPLY_IDENT]);
          else if (rx == cfg_shadow[CFG_CMD_GET_VERSION])
            reply_bytes.push_back(cfg_shadow[CFG_REPLY_VERSION]);
          else if (rx == cfg_shadow[CFG_CMD_READ_FRAME])
            parse_phase = PH_RD_MSB;
          else if (rx == cfg_shadow[CFG_CMD_WRITE_FRAME])
            parse_phase = PH_WR_MSB;
          else
            reply_bytes.push_back(cfg_shadow[CFG_REPLY_ERROR]);
        end
      endcase
    end
    emit_replies();
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_sector();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom_range(0, 3));
    if (r < 50) return recent_sector;
    if (r < 60) return 16'($urandom_range(N_FRAMES - 4, N_FRAMES - 1));
    if (r < 68) return SECTOR_LIMIT;
    if (r < 76) return SECTOR_LIMIT + 16'd1;
    if (r < 84) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Offer one transaction and hold it until the engine takes it
  task automatic push_item(input logic tick, input logic [7:0] rx);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_opcode  <= tick;
    in_rx_byte <= rx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_item(tick, rx);
    items_sent++;
  endtask

  // Stop offering, then wait for every expected result
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Drain, then let a trailing frame copy finish
  task automatic quiesce();
    drain_replies();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] vals [7]);
    int idx;
    for (idx = 0; idx < 7; idx++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(idx);
      cfg_data  <= vals[idx];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      cfg_shadow[idx] = vals[idx];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input int sel);
    logic [7:0] vals [7];
    case (sel)
      1: begin  // extremes
        vals[CFG_CMD_GET_ID]      = 8'h00;
        vals[CFG_CMD_GET_VERSION] = 8'hFF;
        vals[CFG_CMD_READ_FRAME]  = 8'h01;
        vals[CFG_CMD_WRITE_FRAME] = 8'hFE;
        vals[CFG_REPLY_ERROR]     = 8'hFF;
        vals[CFG_REPLY_IDENT]     = 8'h00;
        vals[CFG_REPLY_VERSION]   = 8'hFF;
      end
      2: begin  // every command on one byte: get-id must win
        vals[CFG_CMD_GET_ID]      = 8'h5A;
        vals[CFG_CMD_GET_VERSION] = 8'h5A;
        vals[CFG_CMD_READ_FRAME]  = 8'h5A;
        vals[CFG_CMD_WRITE_FRAME] = 8'h5A;
        vals[CFG_REPLY_ERROR]     = 8'h00;
        vals[CFG_REPLY_IDENT]     = 8'hFF;
        vals[CFG_REPLY_VERSION]   = 8'h80;
      end
      3: begin
        foreach (vals[i]) vals[i] = 8'($urandom);
      end
      default: begin  // version shadows read; replies look like status bytes
        vals[CFG_CMD_GET_ID]      = 8'hA0;
        vals[CFG_CMD_GET_VERSION] = 8'h33;
        vals[CFG_CMD_READ_FRAME]  = 8'h33;
        vals[CFG_CMD_WRITE_FRAME] = 8'hC5;
        vals[CFG_REPLY_ERROR]     = STATUS_GOOD;
        vals[CFG_REPLY_IDENT]     = STATUS_BAD_CSUM;
        vals[CFG_REPLY_VERSION]   = STATUS_BAD_SECTOR;
      end
    endcase
    write_config(vals);
  endtask

  task automatic run_read(input logic [15:0] sec);
    push_item(1'b0, cfg_shadow[CFG_CMD_READ_FRAME]);
    if ($urandom_range(0, 3) == 0) push_item(1'b1, 8'($urandom));
    push_item(1'b0, sec[15:8]);
    push_item(1'b0, sec[7:0]);
  endtask

  // Full frame write; a bad one carries a corrupted checksum
  task automatic run_write(input logic [15:0] sec, input logic good);
    logic [7:0] fold;
    logic [7:0] d;
    int         i;
    fold = sec[15:8] ^ sec[7:0];
    push_item(1'b0, cfg_shadow[CFG_CMD_WRITE_FRAME]);
    push_item(1'b0, sec[15:8]);
    push_item(1'b0, sec[7:0]);
    for (i = 0; i < FRAME_BYTES; i++) begin
      d    = 8'($urandom);
      fold = fold ^ d;
      push_item(1'b0, d);
      if ($urandom_range(0, 19) == 0) push_item(1'b1, 8'($urandom));
    end
    push_item(1'b0, good ? fold : fold ^ 8'($urandom_range(1, 255)));
    if (good && sec < N_FRAMES) recent_sector = sec;
  endtask

  task automatic random_exchange();
    int          r;
    logic [15:0] sec;
    r          = $urandom_range(0, 99);
    burst_mode = ($urandom_range(0, 6) == 0);
    sec        = pick_sector();
    if (r < 12) begin
      repeat ($urandom_range(1, 4)) push_item(1'b1, 8'($urandom));
    end else if (r < 22) begin
      push_item(1'b0, cfg_shadow[CFG_CMD_GET_ID]);
    end else if (r < 30) begin
      push_item(1'b0, cfg_shadow[CFG_CMD_GET_VERSION]);
    end else if (r < 40) begin
      push_item(1'b0, 8'($urandom));
    end else if (r < 66) begin
      run_read(sec);
    end else if (r < 78 && items_sent + FRAME_BYTES + 8 <= ITEMS_TARGET) begin
      // a full frame only while the item budget still holds one
      run_write(sec, $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) run_read(sec);
    end else if (r < 88) begin
      // broken read: the next byte sent lands as the sector LSB
      push_item(1'b0, cfg_shadow[CFG_CMD_READ_FRAME]);
      push_item(1'b0, sec[15:8]);
    end else if (r < 93) begin
      drain_replies();
    end else begin
      // broken write: later traffic is swallowed as frame data
      push_item(1'b0, cfg_shadow[CFG_CMD_WRITE_FRAME]);
      push_item(1'b0, sec[15:8]);
      push_item(1'b0, sec[7:0]);
      repeat ($urandom_range(0, 6)) push_item(1'b0, 8'($urandom));
    end
    burst_mode = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_SHOWN)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Compare each result with the oldest pending transaction reply
  always @(posedge clk) begin : watch_results
    reply_t got;
    reply_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      got = {out_tx_bytes, out_tx_count, out_idle_count, out_last};
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("%0t: unexpected result: expected none, got %h", $time, got);
      end else begin
        want = pending_replies.pop_front();
        results_checked++;
        check_field("tx_bytes", want.tx_bytes, got.tx_bytes);
        check_field("tx_count", 64'(want.tx_count), 64'(got.tx_count));
        check_field("idle_count", 64'(want.idle_count), 64'(got.idle_count));
        check_field("last", 64'(want.last), 64'(got.last));
      end
    end
  end

  initial begin : stimulus
    step_row_t row;
    int        i;
    int        s;
    int        goal;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_opcode  = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = 3'd0;
    cfg_data   = 8'h00;
    burst_mode = 1'b0;
    error_count      = 0;
    results_checked  = 0;
    items_sent       = 0;
    frames_committed = 0;
    recent_sector    = '0;
    cfg_shadow[CFG_CMD_GET_ID]      = 8'hA0;
    cfg_shadow[CFG_CMD_GET_VERSION] = 8'hA1;
    cfg_shadow[CFG_CMD_READ_FRAME]  = 8'hA2;
    cfg_shadow[CFG_CMD_WRITE_FRAME] = 8'hA3;
    cfg_shadow[CFG_REPLY_ERROR]     = 8'hE0;
    cfg_shadow[CFG_REPLY_IDENT]     = 8'hAA;
    cfg_shadow[CFG_REPLY_VERSION]   = 8'h04;
    parse_phase = PH_IDLE;
    sector      = '0;
    wr_index    = '0;
    csum        = '0;
    ticks       = '0;
    foreach (staged[k]) staged[k] = 8'h00;
    foreach (store_img[k]) store_img[k] = 8'hFF;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; typed rows replace the predicted reply
    for (i = 0; i < $size(directed_rows); i++) begin
      row = directed_rows[i];
      push_item(row.is_tick, row.rx);
      if (row.typed) begin
        repeat (last_pushed) void'(pending_replies.pop_back());
        pending_replies.push_back({row.tx, row.cnt, 16'h0000, 1'b1});
      end
    end

    // Random traffic over five register settings, sharing the item budget
    for (s = 0; s < 5; s++) begin
      if (s > 0) begin
        quiesce();
        apply_setting(s);
      end
      if (s == 0) begin
        run_write(16'($urandom_range(0, 3)), 1'b1);
        run_read(recent_sector);
      end
      goal = items_sent + (ITEMS_TARGET - items_sent) / (5 - s);
      while (items_sent < goal) random_exchange();
    end

    quiesce();
    $display("Covered %0d transactions and %0d results: commands, ticks, reads in and",
             items_sent, results_checked);
    $display("past the store, %0d committed frames, reset and four register settings.",
             frames_committed);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== frame_store_serial_command_engine.f =====
src/fssce_pkg.sv
src/frame_store_serial_command_engine.sv
dv/frame_store_serial_command_engine_tb.sv
